[sv/trst_pkg.sv]
// Shared types, codes and helpers for the token range state tracker.
package trst_pkg;

	localparam int PW = 21;
	localparam int MAX_INTERVALS_DEF = 32;
	localparam logic [PW:0] POSITION_LIMIT = (PW+1)'(1048576);

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;

	localparam logic [1:0] ST_UNPROC  = 2'd0;
	localparam logic [1:0] ST_STAGE   = 2'd1;
	localparam logic [1:0] ST_PROC    = 2'd2;
	localparam logic [1:0] ST_UNAVAIL = 2'd3;

	localparam logic [2:0] ERR_OK    = 3'd0;
	localparam logic [2:0] ERR_ARGS  = 3'd1;
	localparam logic [2:0] ERR_TRANS = 3'd2;
	localparam logic [2:0] ERR_FULL  = 3'd3;
	localparam logic [2:0] ERR_OVF   = 3'd4;

	typedef struct packed {
		logic [PW-1:0] end_pos;
		logic [1:0]    st;
	} entry_t;

	// Allowed state moves for an overlapped piece
	function automatic logic trans_ok(input logic [1:0] from_st, input logic [1:0] to_st);
		logic ok;
		begin
			ok = 1'b1;
			if (from_st != to_st) begin
				case (from_st)
					ST_STAGE:  ok = (to_st == ST_PROC);
					ST_PROC:   ok = (to_st == ST_UNPROC);
					ST_UNPROC: ok = (to_st != ST_UNAVAIL);
					default:   ok = 1'b1;
				endcase
			end
			return ok;
		end
	endfunction

endpackage

[sv/trst_table.sv]
// Two-bank interval table memory: one write port, one registered read port.
module trst_table #(
	parameter int IW = 5
) (
	input  logic                clk,
	input  logic                we,
	input  logic [IW:0]         waddr,
	input  trst_pkg::entry_t    wdata,
	input  logic [IW:0]         raddr,
	output trst_pkg::entry_t    rdata
);
	import trst_pkg::*;

	localparam int DEPTH = 2 * (1 << IW);

	entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[sv/token_range_state_tracker.sv]
// Top level: sequencer for clear, append and update over a ping-pong interval table.
//
// Usage: drive operation and the argument ports, raise start while busy is low;
// the transaction is taken at that edge and busy rises the next cycle. When the
// work is done, done pulses for one cycle with error_code and the table summary
// (total_length, first unprocessed range, both prefix ends) on the result ports.
// The receiver cannot hold results off; busy falls in the cycle of the done
// strobe, so a new transaction may be started then.
// Clear and append go straight to the summary scan, which reads each interval
// through the table's registered read port and then evaluates it; with an empty
// table there is nothing to read and done follows. An update first runs the
// rebuild pass (per interval one read state and three push states, all through
// the single table write port, then a flush state) and then the summary scan
// over the resulting intervals. Updates with bad arguments skip the rebuild.
// The update writes its result into the other bank and swaps banks only when it
// succeeds, so a failure leaves the table as was.
// Reset empties the table (count zero); table contents need no clearing.
module token_range_state_tracker
	import trst_pkg::*;
#(
	parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            operation,
	input  logic [PW-1:0]         span_first,
	input  logic [PW-1:0]         span_stop,
	input  logic [PW-1:0]         append_length,
	input  logic [1:0]            target_state,
	output logic                  done,
	output logic [2:0]            error_code,
	output logic [PW-1:0]         total_length,
	output logic                  unprocessed_found,
	output logic [PW-1:0]         unprocessed_start,
	output logic [PW-1:0]         unprocessed_end,
	output logic [PW-1:0]         processed_prefix,
	output logic [PW-1:0]         stage_processed_prefix
);
	localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam int WW = $clog2(MAX_INTERVALS + 3);

	typedef enum logic [2:0] {
		S_IDLE, S_UPD_RD, S_UPD_P0, S_UPD_P1, S_UPD_P2, S_FLUSH, S_SCAN_RD, S_SCAN_EV
	} state_t;

	state_t         state_q;
	logic           bank_q;
	logic [CW-1:0]  cnt_q;
	logic [PW-1:0]  len_q;
	logic [1:0]     last_st_q;
	logic [IW-1:0]  idx_q;
	logic [PW-1:0]  lo_q;
	logic [PW-1:0]  rs_q, re_q;
	logic [1:0]     ns_q;
	logic           placed_q, trans_q, pend_v_q;
	entry_t         pend_q;
	logic [WW-1:0]  wcnt_q;
	logic [2:0]     err_q;
	logic           found_q;
	logic [PW-1:0]  ustart_q, uend_q, pp_q, sp_q;

	logic           we;
	logic [IW:0]    waddr;
	entry_t         wdata;
	entry_t         ent;

	logic           accept, ovl, push_v, coalesce, pend_fits, last_idx;
	logic [PW-1:0]  push_end;
	logic [1:0]     push_st;
	logic [PW:0]    sum;
	logic           app_merge;
	logic [IW-1:0]  app_idx;
	logic [2:0]     app_err;
	logic           upd_bad;
	logic [WW-1:0]  wcnt_next;

	trst_table #(.IW(IW)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr ({bank_q, idx_q}),
		.rdata (ent)
	);

	// request decode, push generation and table write port
	always_comb begin
		accept    = start && (state_q == S_IDLE);
		sum       = {1'b0, len_q} + {1'b0, append_length};
		app_merge = (cnt_q != '0) && (last_st_q == target_state);
		app_idx   = app_merge ? IW'(cnt_q - 1'b1) : IW'(cnt_q);
		if (append_length == '0)
			app_err = ERR_ARGS;
		else if (sum > POSITION_LIMIT)
			app_err = ERR_OVF;
		else if (!app_merge && (cnt_q >= CW'(MAX_INTERVALS)))
			app_err = ERR_FULL;
		else
			app_err = ERR_OK;
		upd_bad = (span_first >= len_q) || (span_stop > len_q) ||
			(span_first >= span_stop);

		ovl      = !((ent.end_pos <= rs_q) || (lo_q >= re_q));
		last_idx = ((CW'(idx_q) + 1'b1) == cnt_q);
		push_v   = 1'b0;
		push_end = ent.end_pos;
		push_st  = ent.st;
		case (state_q)
			S_UPD_P0: begin
				push_v   = ovl && (lo_q < rs_q);
				push_end = rs_q;
			end
			S_UPD_P1: begin
				push_v   = !placed_q && (ovl || (lo_q >= re_q));
				push_end = re_q;
				push_st  = ns_q;
			end
			S_UPD_P2: begin
				push_v   = !ovl || (ent.end_pos > re_q);
			end
			default: push_v = 1'b0;
		endcase
		coalesce  = pend_v_q && (pend_q.st == push_st);
		pend_fits = (wcnt_q < WW'(MAX_INTERVALS));
		wcnt_next = wcnt_q + 1'b1;

		we    = 1'b0;
		waddr = {~bank_q, wcnt_q[IW-1:0]};
		wdata = pend_q;
		if (accept && (operation == OP_APPEND) && (app_err == ERR_OK)) begin
			we    = 1'b1;
			waddr = {bank_q, app_idx};
			wdata = '{end_pos: sum[PW-1:0], st: target_state};
		end else if (push_v && !coalesce && pend_v_q && pend_fits) begin
			we = 1'b1;
		end else if ((state_q == S_FLUSH) && pend_fits) begin
			we = 1'b1;
		end
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bank_q    <= 1'b0;
			cnt_q     <= '0;
			len_q     <= '0;
			last_st_q <= ST_UNPROC;
			done      <= 1'b0;
			pend_v_q  <= 1'b0;
			pend_q    <= '0;
			placed_q  <= 1'b0;
			trans_q   <= 1'b0;
			wcnt_q    <= '0;
			idx_q     <= '0;
			lo_q      <= '0;
			rs_q      <= '0;
			re_q      <= '0;
			ns_q      <= ST_UNPROC;
			err_q     <= ERR_OK;
			found_q   <= 1'b0;
			ustart_q  <= '0;
			uend_q    <= '0;
			pp_q      <= '0;
			sp_q      <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q    <= '0;
						lo_q     <= '0;
						found_q  <= 1'b0;
						ustart_q <= '0;
						uend_q   <= '0;
						pp_q     <= '0;
						sp_q     <= '0;
						rs_q     <= span_first;
						re_q     <= span_stop;
						ns_q     <= target_state;
						placed_q <= 1'b0;
						trans_q  <= 1'b0;
						pend_v_q <= 1'b0;
						wcnt_q   <= '0;
						state_q  <= S_SCAN_RD;
						case (operation)
							OP_CLEAR: begin
								cnt_q <= '0;
								len_q <= '0;
								err_q <= ERR_OK;
							end
							OP_APPEND: begin
								err_q <= app_err;
								if (app_err == ERR_OK) begin
									len_q     <= sum[PW-1:0];
									last_st_q <= target_state;
									if (!app_merge)
										cnt_q <= cnt_q + 1'b1;
								end
							end
							OP_UPDATE: begin
								if (upd_bad) begin
									err_q <= ERR_ARGS;
								end else begin
									state_q <= S_UPD_RD;
								end
							end
							default: err_q <= ERR_ARGS;
						endcase
					end
				end
				S_UPD_RD: state_q <= S_UPD_P0;
				S_UPD_P0, S_UPD_P1, S_UPD_P2: begin
					// one push per cycle, coalescing into the pending entry
					if (push_v) begin
						if (coalesce) begin
							pend_q.end_pos <= push_end;
						end else begin
							if (pend_v_q)
								wcnt_q <= wcnt_next;
							pend_q   <= '{end_pos: push_end, st: push_st};
							pend_v_q <= 1'b1;
						end
					end
					if (state_q == S_UPD_P0) begin
						if (ovl && !trans_ok(ent.st, ns_q))
							trans_q <= 1'b1;
						state_q <= S_UPD_P1;
					end else if (state_q == S_UPD_P1) begin
						if (push_v)
							placed_q <= 1'b1;
						state_q <= S_UPD_P2;
					end else begin
						lo_q <= ent.end_pos;
						if (last_idx) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_UPD_RD;
						end
					end
				end
				S_FLUSH: begin
					// last pending entry written; on success commit by swapping banks
					idx_q <= '0;
					lo_q  <= '0;
					if (trans_q) begin
						err_q <= ERR_TRANS;
					end else if (wcnt_next > WW'(MAX_INTERVALS)) begin
						err_q <= ERR_FULL;
					end else begin
						err_q     <= ERR_OK;
						bank_q    <= ~bank_q;
						cnt_q     <= CW'(wcnt_next);
						last_st_q <= pend_q.st;
					end
					state_q <= S_SCAN_RD;
				end
				S_SCAN_RD: begin
					if (cnt_q == '0) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SCAN_EV;
					end
				end
				S_SCAN_EV: begin
					// summary over stored intervals
					if ((ent.st == ST_UNPROC) && !found_q) begin
						found_q  <= 1'b1;
						ustart_q <= lo_q;
						uend_q   <= ent.end_pos;
					end
					if (ent.st == ST_PROC)
						pp_q <= ent.end_pos;
					if ((ent.st == ST_PROC) || (ent.st == ST_STAGE))
						sp_q <= ent.end_pos;
					lo_q <= ent.end_pos;
					if (last_idx) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy                   = (state_q != S_IDLE);
	assign error_code             = err_q;
	assign total_length           = len_q;
	assign unprocessed_found      = found_q;
	assign unprocessed_start      = ustart_q;
	assign unprocessed_end        = uend_q;
	assign processed_prefix       = pp_q;
	assign stage_processed_prefix = sp_q;

endmodule

[bench/tb_token_range_state_tracker.sv]
// Testbench for the token range state tracker: directed table plus random traffic, scoreboarded.
`timescale 1ns / 1ps

module tb_token_range_state_tracker;
	import trst_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int N_RANDOM = 1300;

	typedef struct {
		logic [2:0]    err;
		logic [PW-1:0] len;
		logic          uf;
		logic [PW-1:0] us;
		logic [PW-1:0] ue;
		logic [PW-1:0] pp;
		logic [PW-1:0] sp;
		bit            fixed;
		logic [2:0]    fixed_err;
		logic [PW-1:0] fixed_len;
	} summary_t;

	typedef struct {
		logic [1:0]    op;
		logic [PW-1:0] rs;
		logic [PW-1:0] re;
		logic [PW-1:0] al;
		logic [1:0]    ns;
		bit            fixed;
		logic [2:0]    err;
		logic [PW-1:0] len;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] operation = OP_CLEAR;
	logic [PW-1:0] span_first = '0;
	logic [PW-1:0] span_stop = '0;
	logic [PW-1:0] append_length = '0;
	logic [1:0] target_state = ST_UNPROC;
	logic busy, done, unprocessed_found;
	logic [2:0] error_code;
	logic [PW-1:0] total_length, unprocessed_start, unprocessed_end;
	logic [PW-1:0] processed_prefix, stage_processed_prefix;

	// typed expectation riding with the current transaction
	bit cur_fixed = 0;
	logic [2:0] cur_err = ERR_OK;
	logic [PW-1:0] cur_len = '0;

	// shadow interval table
	logic [PW:0] tbl_end[MAX_INTERVALS_DEF];
	logic [1:0] tbl_st[MAX_INTERVALS_DEF];
	int tbl_n = 0;
	logic [PW:0] scr_end[MAX_INTERVALS_DEF+3];
	logic [1:0] scr_st[MAX_INTERVALS_DEF+3];
	int scr_n;

	summary_t pending_summaries[$];
	int n_taken = 0;
	int n_fail = 0;
	int cycles = 0;
	int idle_pct = 15;
	int items = 0;

	token_range_state_tracker dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .span_first(span_first), .span_stop(span_stop),
		.append_length(append_length), .target_state(target_state), .done(done),
		.error_code(error_code), .total_length(total_length),
		.unprocessed_found(unprocessed_found), .unprocessed_start(unprocessed_start),
		.unprocessed_end(unprocessed_end), .processed_prefix(processed_prefix),
		.stage_processed_prefix(stage_processed_prefix)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [PW:0] table_length();
		return (tbl_n == 0) ? '0 : tbl_end[tbl_n-1];
	endfunction

	function automatic bit move_ok(input logic [1:0] from_st, input logic [1:0] to_st);
		if (from_st == to_st) return 1;
		if (from_st == ST_STAGE) return to_st == ST_PROC;
		if (from_st == ST_PROC) return to_st == ST_UNPROC;
		if (from_st == ST_UNPROC) return to_st != ST_UNAVAIL;
		return 1;
	endfunction

	// push into scratch table, merging with an equal-state tail
	function automatic void scratch_push(input logic [PW:0] e, input logic [1:0] st);
		if (scr_n > 0 && scr_st[scr_n-1] == st) begin
			scr_end[scr_n-1] = e;
		end else if (scr_n < MAX_INTERVALS_DEF + 3) begin
			scr_end[scr_n] = e;
			scr_st[scr_n] = st;
			scr_n++;
		end
	endfunction

	function automatic logic [2:0] apply_append(input logic [PW:0] len, input logic [1:0] st);
		logic [PW+1:0] total;
		total = table_length() + len;
		if (len == 0) return ERR_ARGS;
		if (total > POSITION_LIMIT) return ERR_OVF;
		if (tbl_n > 0 && tbl_st[tbl_n-1] == st) begin
			tbl_end[tbl_n-1] = total[PW:0];
			return ERR_OK;
		end
		if (tbl_n >= MAX_INTERVALS_DEF) return ERR_FULL;
		tbl_end[tbl_n] = total[PW:0];
		tbl_st[tbl_n] = st;
		tbl_n++;
		return ERR_OK;
	endfunction

	function automatic logic [2:0] apply_update(input logic [PW:0] s, input logic [PW:0] e,
			input logic [1:0] st);
		logic [PW:0] total, lo, hi;
		bit placed;
		total = table_length();
		placed = 0;
		if (s >= total || e > total || s >= e) return ERR_ARGS;
		lo = 0;
		for (int i = 0; i < tbl_n; i++) begin
			hi = tbl_end[i];
			if (lo < e && hi > s && !move_ok(tbl_st[i], st)) return ERR_TRANS;
			lo = hi;
		end
		// rebuild with the new range spliced in
		scr_n = 0;
		lo = 0;
		for (int i = 0; i < tbl_n; i++) begin
			hi = tbl_end[i];
			if (hi <= s || lo >= e) begin
				if (lo >= e && !placed) begin
					scratch_push(e, st);
					placed = 1;
				end
				scratch_push(hi, tbl_st[i]);
			end else begin
				if (lo < s) scratch_push(s, tbl_st[i]);
				if (!placed) begin
					scratch_push(e, st);
					placed = 1;
				end
				if (hi > e) scratch_push(hi, tbl_st[i]);
			end
			lo = hi;
		end
		if (scr_n > MAX_INTERVALS_DEF) return ERR_FULL;
		for (int i = 0; i < scr_n; i++) begin
			tbl_end[i] = scr_end[i];
			tbl_st[i] = scr_st[i];
		end
		tbl_n = scr_n;
		return ERR_OK;
	endfunction

	function automatic summary_t predict_summary(input logic [1:0] op, input logic [PW-1:0] rs,
			input logic [PW-1:0] re, input logic [PW-1:0] al, input logic [1:0] ns);
		summary_t r;
		logic [PW:0] lo;
		r = '{default: '0};
		case (op)
			OP_CLEAR: begin
				tbl_n = 0;
				r.err = ERR_OK;
			end
			OP_APPEND: r.err = apply_append({1'b0, al}, ns);
			OP_UPDATE: r.err = apply_update({1'b0, rs}, {1'b0, re}, ns);
			default: r.err = ERR_ARGS;
		endcase
		lo = 0;
		for (int i = 0; i < tbl_n; i++) begin
			if (tbl_st[i] == ST_UNPROC && !r.uf) begin
				r.uf = 1'b1;
				r.us = lo[PW-1:0];
				r.ue = tbl_end[i][PW-1:0];
			end
			if (tbl_st[i] == ST_PROC) r.pp = tbl_end[i][PW-1:0];
			if (tbl_st[i] == ST_PROC || tbl_st[i] == ST_STAGE) r.sp = tbl_end[i][PW-1:0];
			lo = tbl_end[i];
		end
		lo = table_length();
		r.len = lo[PW-1:0];
		return r;
	endfunction

	// result check first, then take in a new transaction at the same edge
	always @(posedge clk) begin
		summary_t x;
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_summaries.size() == 0) begin
				$display("%0t: unexpected result err=%0d len=%0d", $time, error_code,
					total_length);
				n_fail++;
			end else begin
				x = pending_summaries.pop_front();
				if (error_code !== x.err || total_length !== x.len ||
						unprocessed_found !== x.uf || unprocessed_start !== x.us ||
						unprocessed_end !== x.ue || processed_prefix !== x.pp ||
						stage_processed_prefix !== x.sp ||
						(x.fixed && (x.err !== x.fixed_err || x.len !== x.fixed_len))) begin
					$display("%0t: mismatch exp err=%0d len=%0d uf=%0d us=%0d ue=%0d pp=%0d sp=%0d",
						$time, x.err, x.len, x.uf, x.us, x.ue, x.pp, x.sp);
					$display("%0t:          got err=%0d len=%0d uf=%0d us=%0d ue=%0d pp=%0d sp=%0d",
						$time, error_code, total_length, unprocessed_found,
						unprocessed_start, unprocessed_end, processed_prefix,
						stage_processed_prefix);
					if (x.fixed)
						$display("%0t:          table exp err=%0d len=%0d", $time,
							x.fixed_err, x.fixed_len);
					n_fail++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			x = predict_summary(operation, span_first, span_stop, append_length, target_state);
			x.fixed = cur_fixed;
			x.fixed_err = cur_err;
			x.fixed_len = cur_len;
			pending_summaries.insert(pending_summaries.size(), x);
			n_taken++;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance, or after a random idle gap with start low
	task automatic issue(input logic [1:0] op, input logic [PW-1:0] rs, input logic [PW-1:0] re,
			input logic [PW-1:0] al, input logic [1:0] ns, input bit fx = 0,
			input logic [2:0] ferr = ERR_OK, input logic [PW-1:0] flen = '0);
		int seen;
		seen = n_taken;
		cur_fixed = fx;
		cur_err = ferr;
		cur_len = flen;
		start <= 1'b1;
		operation <= op;
		span_first <= rs;
		span_stop <= re;
		append_length <= al;
		target_state <= ns;
		do @(negedge clk); while (n_taken == seen);
		items++;
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_summaries.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic random_item();
		logic [PW:0] len, s, e;
		int k, pick;
		len = table_length();
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			issue(OP_CLEAR, PW'($urandom), PW'($urandom), PW'($urandom), 2'($urandom));
		end else if (pick < 7) begin
			// raw noise across every field bit
			issue(2'($urandom), PW'($urandom), PW'($urandom), PW'($urandom), 2'($urandom));
		end else if (pick < 10) begin
			issue(OP_APPEND, PW'($urandom), PW'($urandom), PW'($urandom_range(0, 2097151)),
				2'($urandom));
		end else if (pick < 12) begin
			issue(OP_APPEND, PW'($urandom), PW'($urandom), PW'(POSITION_LIMIT - len),
				2'($urandom));
		end else if (pick < 14) begin
			// fill to capacity with alternating states, then split a few
			issue(OP_CLEAR, 0, 0, 0, ST_UNPROC);
			for (int i = 0; i < MAX_INTERVALS_DEF + 2; i++)
				issue(OP_APPEND, 0, 0, PW'($urandom_range(1, 8)),
					(i % 2) ? ST_UNAVAIL : ST_UNPROC);
			repeat (3) begin
				len = table_length();
				s = (PW+1)'($urandom_range(0, len - 2));
				issue(OP_UPDATE, PW'(s), PW'(s + 1), 0, 2'($urandom_range(0, 2)));
			end
		end else if (pick < 45 || len == 0) begin
			issue(OP_APPEND, PW'($urandom), PW'($urandom), PW'($urandom_range(1, 3000)),
				2'($urandom));
		end else begin
			s = (PW+1)'($urandom_range(0, len - 1));
			e = (PW+1)'($urandom_range(s + 1, len));
			// snap the start to an interval boundary part of the time
			if (tbl_n > 1 && $urandom_range(0, 2) == 0) begin
				k = $urandom_range(0, tbl_n - 2);
				s = tbl_end[k];
				if (s >= e) e = len;
			end
			issue(OP_UPDATE, PW'(s), PW'(e), PW'($urandom), 2'($urandom));
		end
	endtask

	row_t directed[] = '{
		'{OP_CLEAR, 0, 0, 0, ST_UNPROC, 1, ERR_OK, 0},
		'{OP_UPDATE, 0, 1, 0, ST_PROC, 1, ERR_ARGS, 0},
		'{2'd3, 0, 0, 0, ST_UNPROC, 1, ERR_ARGS, 0},
		'{OP_APPEND, 0, 0, 0, ST_UNPROC, 1, ERR_ARGS, 0},
		'{OP_APPEND, 0, 0, 21'd1048576, ST_UNPROC, 1, ERR_OK, 21'd1048576},
		'{OP_APPEND, 0, 0, 1, ST_STAGE, 1, ERR_OVF, 21'd1048576},
		'{OP_UPDATE, 0, 21'd1048576, 0, ST_UNAVAIL, 1, ERR_TRANS, 21'd1048576},
		'{OP_UPDATE, 21'd1048576, 21'd1048576, 0, ST_PROC, 1, ERR_ARGS, 21'd1048576},
		'{OP_UPDATE, 5, 5, 0, ST_PROC, 1, ERR_ARGS, 21'd1048576},
		'{OP_UPDATE, 0, 21'h1FFFFF, 0, ST_PROC, 1, ERR_ARGS, 21'd1048576},
		'{OP_UPDATE, 21'h1FFFFF, 3, 0, ST_PROC, 1, ERR_ARGS, 21'd1048576},
		'{OP_UPDATE, 10, 20, 0, ST_STAGE, 0, ERR_OK, 0},
		'{OP_UPDATE, 12, 15, 0, ST_UNPROC, 0, ERR_OK, 0},
		'{OP_UPDATE, 10, 20, 0, ST_PROC, 0, ERR_OK, 0},
		'{OP_UPDATE, 10, 15, 0, ST_UNPROC, 0, ERR_OK, 0},
		'{OP_UPDATE, 0, 21'd1048576, 0, ST_STAGE, 0, ERR_OK, 0},
		'{OP_UPDATE, 0, 21'd1048576, 0, ST_PROC, 0, ERR_OK, 0},
		'{OP_CLEAR, 0, 0, 0, ST_UNPROC, 1, ERR_OK, 0},
		'{OP_APPEND, 0, 0, 7, ST_UNAVAIL, 0, ERR_OK, 0},
		'{OP_APPEND, 0, 0, 5, ST_UNAVAIL, 0, ERR_OK, 0},
		'{OP_UPDATE, 2, 4, 0, ST_STAGE, 0, ERR_OK, 0},
		'{OP_UPDATE, 0, 12, 0, ST_UNPROC, 0, ERR_OK, 0},
		'{OP_APPEND, 0, 0, 21'h1FFFFF, ST_PROC, 1, ERR_OVF, 12},
		'{2'd3, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, ST_UNAVAIL, 1, ERR_ARGS, 12}
	};

	initial begin
		int wait_cycles;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			issue(directed[i].op, directed[i].rs, directed[i].re, directed[i].al,
				directed[i].ns, directed[i].fixed, directed[i].err, directed[i].len);
		wait_drained();

		// sender idling shifts between phases
		items = 0;
		while (items < N_RANDOM) begin
			if (items < N_RANDOM / 3) idle_pct = 15;
			else if (items < 2 * N_RANDOM / 3) idle_pct = 61;
			else idle_pct = 0;
			if (items > N_RANDOM / 2 && items < N_RANDOM / 2 + 3) wait_drained();
			random_item();
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (pending_summaries.size() != 0 && wait_cycles < 20000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (300) @(negedge clk);
		if (n_fail == 0 && pending_summaries.size() == 0) begin
			$display("CHECK OK");
		end else begin
			if (pending_summaries.size() != 0)
				$display("%0t: %0d results never arrived", $time, pending_summaries.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
